@@ rtl/xibe_pkg.sv @@
// ----------------------------------------------------------------------------
// x86 instruction byte encoder package
// Shared constants, slot layout and the queue entry type.
// ----------------------------------------------------------------------------
package xibe_pkg;

    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 8;
    localparam int NUM_SLOTS   = 14;

    localparam int DEFAULT_QUEUE_DEPTH = 2;

    // Input field offsets inside the slave tdata.
    localparam int OFS_PREFIX = 0;
    localparam int OFS_OPCODE = 3;
    localparam int OFS_MODRM  = 11;
    localparam int OFS_MOD    = 12;
    localparam int OFS_REG    = 14;
    localparam int OFS_RM     = 18;
    localparam int OFS_SCALE  = 22;
    localparam int OFS_INDEX  = 24;
    localparam int OFS_BASE   = 28;
    localparam int OFS_DISP   = 32;
    localparam int OFS_IMM    = 64;
    localparam int OFS_ISZ    = 96;

    // Fixed byte slots in emission order.
    localparam int SLOT_OPSIZE = 0;
    localparam int SLOT_REX    = 1;
    localparam int SLOT_ESC    = 2;
    localparam int SLOT_OPC    = 3;
    localparam int SLOT_MODRM  = 4;
    localparam int SLOT_SIB    = 5;
    localparam int SLOT_DISP   = 6;
    localparam int SLOT_IMM    = 10;

    localparam logic [7:0] BYTE_OPSIZE = 8'h66;
    localparam logic [7:0] BYTE_ESC    = 8'h0F;
    localparam logic [3:0] REX_W_HIGH  = 4'h4;

    localparam int PF_OPSIZE = 0;
    localparam int PF_REX    = 1;
    localparam int PF_ESC    = 2;

    localparam logic [1:0] MOD_NODISP = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISP32 = 2'd2;
    localparam logic [1:0] MOD_REG    = 2'd3;

    localparam logic [2:0] RM_SIB    = 3'd4;
    localparam logic [2:0] RM_DISP32 = 3'd5;

    localparam logic [1:0] ISZ_NONE = 2'd0;
    localparam logic [1:0] ISZ_ONE  = 2'd1;
    localparam logic [1:0] ISZ_TWO  = 2'd2;
    localparam logic [1:0] ISZ_FOUR = 2'd3;

    typedef struct packed {
        logic [NUM_SLOTS-1:0]      mask;
        logic [NUM_SLOTS-1:0][7:0] bytes;
    } t_entry;

endpackage

@@ rtl/x86_instruction_byte_encoder.sv @@
// ----------------------------------------------------------------------------
// x86 instruction byte encoder
// Turns one decoded instruction description into its machine code bytes.
// ----------------------------------------------------------------------------
// Each accepted description yields 1 to 14 byte transfers on the master side,
// one per cycle while i_m_axis_tready is high, with tlast on the final byte;
// the single-byte output port limits the sustained input rate of descriptions.
// A description enters the front register the cycle after it is accepted; its
// first byte then passes through the queue and the sequencer's slot registers
// into the output register. The front register plus QUEUE_DEPTH queue entries
// let the slave side keep accepting while the output stalls or serializes.
module x86_instruction_byte_encoder import xibe_pkg::*; #(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // prefix_flags[2:0], opcode[10:3], has_modrm[11], addr_mode[13:12],
    // reg_field[17:14], rm_field[21:18], scale[23:22], index_reg[27:24],
    // base_reg[31:28], displacement[63:32], immediate[95:64],
    // imm_size[97:96], zero fill[103:98]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // code_byte[7:0]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                   o_m_axis_tlast
);

    logic   front_valid;
    logic   front_ready;
    t_entry front_entry;
    logic   queue_valid;
    logic   queue_ready;
    t_entry queue_entry;

    xibe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tvalid    (i_s_axis_tvalid),
        .o_tready    (o_s_axis_tready),
        .i_tdata     (i_s_axis_tdata),
        .o_ent_valid (front_valid),
        .i_ent_ready (front_ready),
        .o_entry     (front_entry)
    );

    xibe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_entry (front_entry),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (queue_ready),
        .o_pop_entry  (queue_entry)
    );

    xibe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ent_valid (queue_valid),
        .o_ent_ready (queue_ready),
        .i_entry     (queue_entry),
        .o_tvalid    (o_m_axis_tvalid),
        .i_tready    (i_m_axis_tready),
        .o_tdata     (o_m_axis_tdata),
        .o_tlast     (o_m_axis_tlast)
    );

endmodule

@@ rtl/xibe_front.sv @@
// ----------------------------------------------------------------------------
// Encoder front end
// Accepts instruction descriptions and lays their bytes into fixed slots.
// ----------------------------------------------------------------------------
module xibe_front import xibe_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_tvalid,
    output logic                  o_tready,
    input  logic [IN_TDATA_W-1:0] i_tdata,
    output logic                  o_ent_valid,
    input  logic                  i_ent_ready,
    output t_entry                o_entry
);

    logic         r_valid;
    t_entry       r_entry;
    t_entry       n_entry;

    logic [2:0]   pf;
    logic [7:0]   opc;
    logic         has_modrm;
    logic [1:0]   mod_f;
    logic [3:0]   reg_f;
    logic [3:0]   rm_f;
    logic [1:0]   scale_f;
    logic [3:0]   idx_f;
    logic [3:0]   base_f;
    logic [31:0]  disp;
    logic [31:0]  imm;
    logic [1:0]   isz;
    logic         sib;
    logic         disp1;
    logic         disp4;
    logic         take;

    assign pf        = i_tdata[OFS_PREFIX +: 3];
    assign opc       = i_tdata[OFS_OPCODE +: 8];
    assign has_modrm = i_tdata[OFS_MODRM];
    assign mod_f     = i_tdata[OFS_MOD +: 2];
    assign reg_f     = i_tdata[OFS_REG +: 4];
    assign rm_f      = i_tdata[OFS_RM +: 4];
    assign scale_f   = i_tdata[OFS_SCALE +: 2];
    assign idx_f     = i_tdata[OFS_INDEX +: 4];
    assign base_f    = i_tdata[OFS_BASE +: 4];
    assign disp      = i_tdata[OFS_DISP +: 32];
    assign imm       = i_tdata[OFS_IMM +: 32];
    assign isz       = i_tdata[OFS_ISZ +: 2];

    assign sib   = (mod_f != MOD_REG) && (rm_f[2:0] == RM_SIB);
    assign disp1 = has_modrm && (mod_f == MOD_DISP8);
    assign disp4 = has_modrm && ((mod_f == MOD_DISP32) ||
                   ((mod_f == MOD_NODISP) &&
                    ((rm_f[2:0] == RM_DISP32) || (sib && (base_f[2:0] == RM_DISP32)))));

    always_comb begin
        n_entry = '0;
        n_entry.bytes[SLOT_OPSIZE] = BYTE_OPSIZE;
        n_entry.bytes[SLOT_REX]    = {REX_W_HIGH, 1'b1, reg_f[3],
                                      sib & idx_f[3], sib ? base_f[3] : rm_f[3]};
        n_entry.bytes[SLOT_ESC]    = BYTE_ESC;
        n_entry.bytes[SLOT_OPC]    = opc;
        n_entry.bytes[SLOT_MODRM]  = {mod_f, reg_f[2:0], rm_f[2:0]};
        n_entry.bytes[SLOT_SIB]    = {scale_f, idx_f[2:0], base_f[2:0]};
        for (int i = 0; i < 4; i++) begin
            n_entry.bytes[SLOT_DISP + i] = disp[8*i +: 8];
            n_entry.bytes[SLOT_IMM + i]  = imm[8*i +: 8];
        end
        n_entry.mask[SLOT_OPSIZE]    = pf[PF_OPSIZE];
        n_entry.mask[SLOT_REX]       = pf[PF_REX];
        n_entry.mask[SLOT_ESC]       = pf[PF_ESC];
        n_entry.mask[SLOT_OPC]       = 1'b1;
        n_entry.mask[SLOT_MODRM]     = has_modrm;
        n_entry.mask[SLOT_SIB]       = has_modrm && sib;
        n_entry.mask[SLOT_DISP]      = disp1 || disp4;
        n_entry.mask[SLOT_DISP + 1]  = disp4;
        n_entry.mask[SLOT_DISP + 2]  = disp4;
        n_entry.mask[SLOT_DISP + 3]  = disp4;
        n_entry.mask[SLOT_IMM]       = (isz != ISZ_NONE);
        n_entry.mask[SLOT_IMM + 1]   = (isz == ISZ_TWO) || (isz == ISZ_FOUR);
        n_entry.mask[SLOT_IMM + 2]   = (isz == ISZ_FOUR);
        n_entry.mask[SLOT_IMM + 3]   = (isz == ISZ_FOUR);
    end

    assign o_tready    = !r_valid || i_ent_ready;
    assign take        = i_tvalid && o_tready;
    assign o_ent_valid = r_valid;
    assign o_entry     = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_tready) begin
            r_valid <= i_tvalid;
        end
        if (take) begin
            r_entry <= n_entry;
        end
    end

endmodule

@@ rtl/xibe_queue.sv @@
// ----------------------------------------------------------------------------
// Encoder slot queue
// Small register queue that decouples the front end from the byte sequencer.
// ----------------------------------------------------------------------------
module xibe_queue import xibe_pkg::*; #(
    parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_valid,
    output logic   o_push_ready,
    input  t_entry i_push_entry,
    output logic   o_pop_valid,
    input  logic   i_pop_ready,
    output t_entry o_pop_entry
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_entry  = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    a_push_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) && push |=> o_pop_valid)
        else $error("entry pushed into empty queue is not visible");

    a_ptr_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) || (r_count == CNT_W'(DEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule

@@ rtl/xibe_back.sv @@
// ----------------------------------------------------------------------------
// Encoder byte sequencer
// Walks the valid slots of one entry and sends one code byte per transfer.
// ----------------------------------------------------------------------------
module xibe_back import xibe_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_ent_valid,
    output logic                   o_ent_ready,
    input  t_entry                 i_entry,
    output logic                   o_tvalid,
    input  logic                   i_tready,
    output logic [OUT_TDATA_W-1:0] o_tdata,
    output logic                   o_tlast
);

    logic [NUM_SLOTS-1:0]      r_mask;
    logic [NUM_SLOTS-1:0]      n_mask;
    logic [NUM_SLOTS-1:0][7:0] r_bytes;
    logic                      r_out_valid;
    logic                      n_out_valid;
    logic [7:0]                r_out_data;
    logic [7:0]                n_out_data;
    logic                      r_out_last;
    logic                      n_out_last;

    logic [NUM_SLOTS-1:0]      pick;
    logic [NUM_SLOTS-1:0]      rest;
    logic [7:0]                sel_byte;
    logic                      out_free;
    logic                      emit;
    logic                      load;

    assign pick     = r_mask & (~r_mask + 1'b1);
    assign rest     = r_mask & ~pick;
    assign out_free = !r_out_valid || i_tready;
    assign emit     = out_free && (r_mask != '0);

    assign o_ent_ready = (r_mask == '0) || (emit && (rest == '0));
    assign load        = i_ent_valid && o_ent_ready;

    always_comb begin
        sel_byte = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            sel_byte = sel_byte | (r_bytes[i] & {8{pick[i]}});
        end
    end

    always_comb begin
        n_mask      = r_mask;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        if (load) begin
            n_mask = i_entry.mask;
        end else if (emit) begin
            n_mask = rest;
        end
        if (emit) begin
            n_out_valid = 1'b1;
            n_out_data  = sel_byte;
            n_out_last  = (rest == '0);
        end else if (i_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask      <= n_mask;
            r_out_valid <= n_out_valid;
        end
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
        if (load) begin
            r_bytes <= i_entry.bytes;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;
    assign o_tlast  = r_out_last;

    a_one_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> $onehot(pick))
        else $error("sequencer picked no single slot");

    a_opcode_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_mask[SLOT_OPC])
        else $error("loaded entry lacks the opcode slot");

    a_mid_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && (rest != '0) |=> o_tvalid && !o_tlast && (r_mask != '0))
        else $error("byte marked last while slots remain");

endmodule
